// ===== sv/iprt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_pkg: shared types and constants of the IPv4 route lookup core
// Item and result layouts, status codes, table entry and match unit control.
// ----------------------------------------------------------------------------
package iprt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int PORT_COUNT_DEF  = 4;

  localparam logic [7:0]  PROTO_UDP    = 8'h11;
  localparam logic [13:0] METRIC_LIMIT = 14'd10000;

  localparam logic       ACT_WRITE = 1'b0;
  localparam logic       ACT_ROUTE = 1'b1;

  localparam logic [2:0] ST_FORWARD     = 3'd0;
  localparam logic [2:0] ST_NOT_UDP     = 3'd1;
  localparam logic [2:0] ST_TTL_EXPIRED = 3'd2;
  localparam logic [2:0] ST_NO_ROUTE    = 3'd3;
  localparam logic [2:0] ST_WRITTEN     = 3'd4;

  typedef struct packed {
    logic        action;
    logic [3:0]  entry_index;
    logic [31:0] entry_network;
    logic [31:0] entry_mask;
    logic [1:0]  entry_port;
    logic [13:0] entry_metric;
    logic [7:0]  packet_protocol;
    logic [7:0]  packet_ttl;
    logic [31:0] dst_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] egress_port;
    logic [7:0] new_ttl;
  } out_item_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [1:0]  port;
    logic [13:0] metric;
  } route_entry_t;

  typedef struct packed {
    logic clear;
    logic step;
  } match_ctl_t;

endpackage

// ===== sv/iprt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_table: route table memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iprt_table #(
  parameter int  DEPTH = iprt_pkg::TABLE_DEPTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  iprt_pkg::route_entry_t wr_data,
  input  logic [AW-1:0]         rd_addr,
  output iprt_pkg::route_entry_t rd_data
);

  iprt_pkg::route_entry_t mem [DEPTH];
  iprt_pkg::route_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/iprt_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprt_match: shared masked comparator and lowest metric tracker
// Check one entry per step; keep the first entry with the smallest metric.
// ----------------------------------------------------------------------------
module iprt_match (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iprt_pkg::match_ctl_t   ctl,
  input  logic [31:0]            dst,
  input  iprt_pkg::route_entry_t entry,
  output logic                   found,
  output logic [1:0]             best_port
);

  logic        found_r, found_nxt;
  logic [13:0] best_r, best_nxt;
  logic [1:0]  port_r, port_nxt;
  logic        hit;

  // strict less-than keeps the earlier entry on a tie
  assign hit = (((dst ^ entry.network) & entry.mask) == 32'd0) && (entry.metric < best_r);

  always_comb begin
    found_nxt = found_r;
    best_nxt  = best_r;
    port_nxt  = port_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
      best_nxt  = iprt_pkg::METRIC_LIMIT;
      port_nxt  = 2'd0;
    end else if (ctl.step && hit) begin
      found_nxt = 1'b1;
      best_nxt  = entry.metric;
      port_nxt  = entry.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    port_r <= port_nxt;
  end

  assign found     = found_r;
  assign best_port = port_r;

endmodule

// ===== sv/ipv4_min_metric_route_lookup_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_min_metric_route_lookup_core: IPv4 lowest metric route lookup
// Route table with write items and a sequential lowest-metric search.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time and always yields one result
// transfer. A write item, a packet that is not UDP and a packet whose TTL
// reaches zero go from the accept state straight to the output stage, as
// does a routed packet when route_count is zero (route_count is clamped to
// TABLE_DEPTH). Other routed packets scan the table; its single read port
// means a shared masked comparator and metric tracker checks one entry per
// cycle on the registered read data; a drain state covers the last compare.
// The output register holds a finished result while the next item is taken;
// a new result waits until that register is free. route_count is written
// through the cfg_ port and must only change while the block is idle. Table
// contents come up undefined after reset; load every entry below route_count
// before routing packets.
// ----------------------------------------------------------------------------
module ipv4_min_metric_route_lookup_core #(
  parameter int TABLE_DEPTH = iprt_pkg::TABLE_DEPTH_DEF,
  parameter int PORT_COUNT  = iprt_pkg::PORT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  iprt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output iprt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int LW    = (CNT_W > 5) ? CNT_W : 5;

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [4:0]          route_count_r;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [AW-1:0]       last_r, last_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [31:0]         dst_r, dst_nxt;
  logic [7:0]          ttl_r, ttl_nxt;
  logic [2:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  iprt_pkg::out_item_t out_data_r, out_data_nxt;

  logic                   in_xfer;
  logic                   out_free;
  logic [7:0]             ttl_dec;
  logic [LW-1:0]          count_ext;
  logic [LW-1:0]          limit;
  logic                   wr_en;
  logic                   index_ok;
  iprt_pkg::route_entry_t wr_entry;
  iprt_pkg::route_entry_t rd_entry;
  iprt_pkg::match_ctl_t   match_ctl;
  logic                   found;
  logic [1:0]             best_port;
  logic [1:0]             port_red;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  // configuration: entries in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_count_r <= 5'd0;
    end else if (cfg_valid && cfg_ready) begin
      route_count_r <= cfg_data;
    end
  end

  // clamp the count to the table size
  assign count_ext = LW'(route_count_r);
  assign limit     = (count_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : count_ext;
  assign ttl_dec   = in_data.packet_ttl - 8'd1;

  // reduce the stored port modulo PORT_COUNT; the 2-bit value stays below
  // twice the port count when PORT_COUNT is two or more, so one compare and subtract does it
  always_comb begin
    port_red = in_data.entry_port;
    if (7'(in_data.entry_port) >= 7'(PORT_COUNT)) begin
      port_red = in_data.entry_port - 2'(PORT_COUNT);
    end
  end

  assign index_ok          = 9'(in_data.entry_index) < 9'(TABLE_DEPTH);
  assign wr_en             = in_xfer && (in_data.action == iprt_pkg::ACT_WRITE) && index_ok;
  assign wr_entry.network  = in_data.entry_network;
  assign wr_entry.mask     = in_data.entry_mask;
  assign wr_entry.port     = port_red;
  assign wr_entry.metric   = in_data.entry_metric;

  // clear the tracker on every transfer in, step it on each read data beat
  assign match_ctl.clear = in_xfer;
  assign match_ctl.step  = rd_vld_r;

  iprt_table #(
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(in_data.entry_index)),
    .wr_data(wr_entry),
    .rd_addr(idx_r),
    .rd_data(rd_entry)
  );

  iprt_match u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (match_ctl),
    .dst      (dst_r),
    .entry    (rd_entry),
    .found    (found),
    .best_port(best_port)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    rd_vld_nxt    = 1'b0;
    dst_nxt       = dst_r;
    ttl_nxt       = ttl_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_FINISH;
          ttl_nxt   = 8'd0;
          if (in_data.action == iprt_pkg::ACT_WRITE) begin
            status_nxt = iprt_pkg::ST_WRITTEN;
          end else if (in_data.packet_protocol != iprt_pkg::PROTO_UDP) begin
            status_nxt = iprt_pkg::ST_NOT_UDP;
          end else if (ttl_dec == 8'd0) begin
            status_nxt = iprt_pkg::ST_TTL_EXPIRED;
          end else begin
            // no route until the scan finds one
            status_nxt = iprt_pkg::ST_NO_ROUTE;
            ttl_nxt    = ttl_dec;
            dst_nxt    = in_data.dst_address;
            idx_nxt    = '0;
            last_nxt   = AW'(limit - LW'(1));
            if (limit != '0) begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // issue one table read per cycle
        rd_vld_nxt = 1'b1;
        if (idx_r == last_r) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_DRAIN: begin
        // last entry is compared this cycle
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register frees up
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.new_ttl = ttl_r;
          if ((status_r == iprt_pkg::ST_NO_ROUTE) && found) begin
            out_data_nxt.status      = iprt_pkg::ST_FORWARD;
            out_data_nxt.egress_port = best_port;
          end else begin
            out_data_nxt.status      = status_r;
            out_data_nxt.egress_port = 2'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    last_r     <= last_nxt;
    dst_r      <= dst_nxt;
    ttl_r      <= ttl_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/route_verdict_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_verdict_checker: result checker for the IPv4 route lookup core
// Watches the item, result and cfg channels, keeps its own route table and
// count, works out the verdict of every accepted item and compares it field
// by field with the result transfers in order.
// ----------------------------------------------------------------------------
module route_verdict_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  iprt_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  iprt_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  iprt_pkg::route_entry_t routes [iprt_pkg::TABLE_DEPTH_DEF];
  logic [4:0]             route_limit;
  iprt_pkg::out_item_t    expected_verdicts [$];

  // Apply one item to the table copy and return the verdict it should produce.
  function automatic iprt_pkg::out_item_t forward_decision(input iprt_pkg::in_item_t it);
    iprt_pkg::out_item_t res;
    logic [7:0]          ttl_left;
    logic [13:0]         best;
    logic [1:0]          port;
    logic                hit;
    int                  span;
    int                  i;
    res = '0;
    if (it.action == iprt_pkg::ACT_WRITE) begin
      routes[it.entry_index].network = it.entry_network;
      routes[it.entry_index].mask    = it.entry_mask;
      routes[it.entry_index].port    = it.entry_port;
      routes[it.entry_index].metric  = it.entry_metric;
      res.status = iprt_pkg::ST_WRITTEN;
      return res;
    end
    if (it.packet_protocol != iprt_pkg::PROTO_UDP) begin
      res.status = iprt_pkg::ST_NOT_UDP;
      return res;
    end
    ttl_left = it.packet_ttl - 8'd1;
    if (ttl_left == 8'd0) begin
      res.status = iprt_pkg::ST_TTL_EXPIRED;
      return res;
    end
    // Saturate the count at the table depth.
    span = (int'(route_limit) > iprt_pkg::TABLE_DEPTH_DEF) ?
           iprt_pkg::TABLE_DEPTH_DEF : int'(route_limit);
    best = iprt_pkg::METRIC_LIMIT;
    port = '0;
    hit  = 1'b0;
    for (i = 0; i < span; i++) begin
      if (((it.dst_address & routes[i].mask) == (routes[i].network & routes[i].mask))
          && (routes[i].metric < best)) begin
        best = routes[i].metric;
        port = routes[i].port;
        hit  = 1'b1;
      end
    end
    res.new_ttl     = ttl_left;
    res.status      = hit ? iprt_pkg::ST_FORWARD : iprt_pkg::ST_NO_ROUTE;
    res.egress_port = hit ? port : 2'd0;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    iprt_pkg::out_item_t want;
    if (!rst_n) begin
      expected_verdicts.delete();
      route_limit = '0;
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result transfer: status %0d port %0d ttl %0d",
                 out_data.status, out_data.egress_port, out_data.new_ttl);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
          if (out_data.egress_port !== want.egress_port) begin
            $error("egress_port: expected %0d, got %0d",
                   want.egress_port, out_data.egress_port);
            mismatches++;
          end
          if (out_data.new_ttl !== want.new_ttl) begin
            $error("new_ttl: expected %0d, got %0d", want.new_ttl, out_data.new_ttl);
            mismatches++;
          end
        end
      end
      // an item taken at this edge still sees the count from before it
      if (in_valid && !in_stall) expected_verdicts.push_back(forward_decision(in_data));
      if (cfg_valid && cfg_ready) route_limit = cfg_data;
      outstanding = expected_verdicts.size();
    end
  end

endmodule

// ===== test/ipv4_min_metric_route_lookup_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_min_metric_route_lookup_core_test: stimulus top for the route lookup
// Drives table writes and packets into the core under several route counts
// and handshake pressure patterns; a side checker predicts each verdict and
// this top reports the outcome.
// ----------------------------------------------------------------------------
module ipv4_min_metric_route_lookup_core_test;

  // Cycles without any transfer on any channel before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // Length of the deliberate receiver hold-off used to back the core up.
  localparam int HOLD_CYCLES = 400;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  iprt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  iprt_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [4:0]          cfg_data;

  int          mismatches;
  int          outstanding;
  int          idle_pct;
  int          stall_pct;
  int          hold_left;
  int          quiet;
  logic [31:0] net_pool [4];

  ipv4_min_metric_route_lookup_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  route_verdict_checker route_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: hold off for a counted stretch when asked, otherwise stall
  // at the rate of the current phase. Change only at the falling edge.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: restart on any transfer, give up after a long quiet stretch.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : (~32'h0 << (32 - len));
  endfunction

  // Every field random, so that fields an item does not use still toggle.
  function automatic iprt_pkg::in_item_t scrambled();
    iprt_pkg::in_item_t it;
    it.action          = 1'($urandom);
    it.entry_index     = 4'($urandom);
    it.entry_network   = $urandom;
    it.entry_mask      = $urandom;
    it.entry_port      = 2'($urandom);
    it.entry_metric    = 14'($urandom);
    it.packet_protocol = 8'($urandom);
    it.packet_ttl      = 8'($urandom);
    it.dst_address     = $urandom;
    return it;
  endfunction

  // Shape a write so that its network sits under one of the shared prefixes and
  // its metric often ties or lands near the cutoff.
  function automatic iprt_pkg::in_item_t shaped_entry(input iprt_pkg::in_item_t it);
    logic [31:0] mask;
    int          roll;
    it.action = iprt_pkg::ACT_WRITE;
    if ($urandom_range(99) < 10) mask = $urandom;
    else if ($urandom_range(99) < 70) mask = prefix_mask($urandom_range(8, 24));
    else mask = prefix_mask($urandom_range(0, 32));
    it.entry_mask    = mask;
    it.entry_network = (net_pool[$urandom_range(3)] & mask) | ($urandom & ~mask);
    roll = $urandom_range(99);
    if (roll < 55) it.entry_metric = 14'($urandom_range(7));
    else if (roll < 70) it.entry_metric = 14'($urandom_range(9990, 10010));
    else if (roll < 75) it.entry_metric = 14'h3FFF;
    else if (roll < 80) it.entry_metric = 14'd0;
    else it.entry_metric = 14'($urandom);
    return it;
  endfunction

  function automatic iprt_pkg::in_item_t next_item();
    iprt_pkg::in_item_t it;
    int                 roll;
    it = scrambled();
    if ($urandom_range(99) < 25) return shaped_entry(it);
    it.action = iprt_pkg::ACT_ROUTE;
    if ($urandom_range(99) < 85) it.packet_protocol = iprt_pkg::PROTO_UDP;
    roll = $urandom_range(99);
    if (roll < 8) it.packet_ttl = 8'd1;
    else if (roll < 14) it.packet_ttl = 8'd0;
    else if (roll < 18) it.packet_ttl = 8'd2;
    else if (roll < 22) it.packet_ttl = 8'hFF;
    // Most destinations fall inside one of the shared prefixes.
    if ($urandom_range(99) < 75)
      it.dst_address = net_pool[$urandom_range(3)] ^
                       ($urandom & ~prefix_mask($urandom_range(8, 32)));
    return it;
  endfunction

  // Offer one item, after an optional idle gap; hold it until it is taken.
  // Called and returns just after a falling edge.
  task automatic offer(input iprt_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_data  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
  endtask

  // Change the count only with the core idle: every verdict back, then settle.
  task automatic set_route_count(input logic [4:0] count);
    drain();
    repeat (4) @(negedge clk);
    cfg_data  = count;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_entry(input logic [3:0] slot, input logic [31:0] net,
                            input logic [31:0] mask, input logic [1:0] port,
                            input logic [13:0] cost);
    iprt_pkg::in_item_t it;
    it = scrambled();
    it.action        = iprt_pkg::ACT_WRITE;
    it.entry_index   = slot;
    it.entry_network = net;
    it.entry_mask    = mask;
    it.entry_port    = port;
    it.entry_metric  = cost;
    offer(it);
  endtask

  task automatic offer_packet(input logic [7:0] proto, input logic [7:0] ttl,
                              input logic [31:0] dst);
    iprt_pkg::in_item_t it;
    it = scrambled();
    it.action          = iprt_pkg::ACT_ROUTE;
    it.packet_protocol = proto;
    it.packet_ttl      = ttl;
    it.dst_address     = dst;
    offer(it);
  endtask

  task automatic run_phase(input logic [4:0] count, input int send_gap,
                           input int recv_stall, input int n);
    set_route_count(count);
    idle_pct  = send_gap;
    stall_pct = recv_stall;
    repeat (n) offer(next_item());
  endtask

  initial begin : stimulus
    int slot;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    quiet     = 0;
    foreach (net_pool[i]) net_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: drops that never read the table, with the count still zero.
    offer_packet(8'h00, 8'h80, 32'h0A000001);   // not UDP
    offer_packet(8'hFF, 8'h40, 32'hFFFFFFFF);   // not UDP, top protocol
    offer_packet(iprt_pkg::PROTO_UDP, 8'd1, 32'h0A000001); // TTL expires
    offer_packet(iprt_pkg::PROTO_UDP, 8'd0, 32'h00000000); // TTL wraps, empty table

    // Load a small table: catch-all at the cutoff, exact host at top metric,
    // a tie on one prefix, a longer prefix that loses on metric, a zero metric.
    load_entry(4'd0, 32'h00000000, 32'h00000000, 2'd3, 14'd10000);
    load_entry(4'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd0, 14'h3FFF);
    load_entry(4'd2, 32'h0A000000, 32'hFF000000, 2'd1, 14'd100);
    load_entry(4'd3, 32'h0A000000, 32'hFF000000, 2'd2, 14'd100);
    load_entry(4'd4, 32'h0A0B0000, 32'hFFFF0000, 2'd3, 14'd9999);
    load_entry(4'd5, 32'hC0A80100, 32'hFFFFFF00, 2'd2, 14'd0);
    load_entry(4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd1, 14'd9999);
    load_entry(4'd6, 32'hFFFFFFFF, 32'hFFFFFFFF, 2'd1, 14'd9999);

    set_route_count(5'd7);
    offer_packet(iprt_pkg::PROTO_UDP, 8'hFF, 32'h0A0B0C0D);  // tie, earlier entry wins
    offer_packet(iprt_pkg::PROTO_UDP, 8'd2, 32'h0A000001);   // forwarded with TTL 1
    offer_packet(iprt_pkg::PROTO_UDP, 8'd64, 32'hC0A80105);  // zero metric
    offer_packet(iprt_pkg::PROTO_UDP, 8'd0, 32'hFFFFFFFF);   // host route below cutoff
    offer_packet(iprt_pkg::PROTO_UDP, 8'd128, 32'h08080808); // only match is at the cutoff
    set_route_count(5'd1);
    offer_packet(iprt_pkg::PROTO_UDP, 8'd9, 32'h0A000001);   // count hides real routes

    // Fill the whole table, then run flat out.
    set_route_count(5'd16);
    for (slot = 0; slot < iprt_pkg::TABLE_DEPTH_DEF; slot++) begin
      in_data = shaped_entry(scrambled());
      in_data.entry_index = 4'(slot);
      offer(in_data);
    end
    repeat (380) offer(next_item());

    run_phase(5'd31, 68, 0, 300);   // count past the depth saturates
    run_phase(5'd0, 0, 68, 150);
    run_phase(5'd1, 17, 17, 250);

    // Back the core up: hold the result side while items keep coming.
    set_route_count(5'd16);
    idle_pct  = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (250) offer(next_item());

    run_phase(5'($urandom_range(2, 15)), 17, 17, 300);
    run_phase(5'd16, 68, 68, 120);

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
